/* rtl/sdf_fmt_pkg.sv */
// shared constants, codes and helpers for the signed decimal field formatter
`timescale 1ns / 1ps

package sdf_fmt_pkg;

  // saturation limit for field width and precision
  localparam int unsigned FIELD_LIMIT = 63;

  // bcd digits needed for the largest magnitude, 2^63
  localparam int unsigned NUM_BCD = 19;
  localparam int unsigned BCD_W   = 4 * NUM_BCD;

  // ascii codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // size modes
  localparam logic [2:0] SZ_INT   = 3'd0;
  localparam logic [2:0] SZ_LONG  = 3'd1;
  localparam logic [2:0] SZ_LLONG = 3'd2;
  localparam logic [2:0] SZ_SHORT = 3'd3;
  localparam logic [2:0] SZ_CHAR  = 3'd4;

  // flag bit positions
  localparam int unsigned FL_LEFT  = 0;
  localparam int unsigned FL_PLUS  = 1;
  localparam int unsigned FL_SPACE = 2;
  localparam int unsigned FL_ZERO  = 3;

  // explicit zero precision code
  localparam logic [6:0] PREC_EXPL_ZERO = 7'h7F;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_NORM = 5'b00100,
    ST_SIZE = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  // double dabble correction: add three to every digit of five or more
  function automatic logic [BCD_W-1:0] bcd_adj(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    r = v;
    for (int k = 0; k < NUM_BCD; k++) begin
      if (v[4*k +: 4] >= 4'd5) begin
        r[4*k +: 4] = v[4*k +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/signed_decimal_field_formatter_core.sv */
// top level of the signed decimal field formatter
`timescale 1ns / 1ps
// after acceptance an item goes through conversion, leading-zero stripping, sizing and
// emission; the bit-serial double dabble loop takes in 8, 16, 32 or 64 magnitude bits by
// size mode, and the emitter gives one character per cycle, or a lone empty-field marker
// no new request is taken until the block goes idle with the last word of an item; words
// are registered and cannot be held off
// rst_ni clears the sequencer and the word strobe asynchronously; no clearing pass is needed

module signed_decimal_field_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] arg_bits_i,
  input  logic [2:0]  size_mode_i,
  input  logic [3:0]  flag_set_i,
  input  logic [5:0]  field_width_i,
  input  logic [6:0]  precision_i,
  output logic        word_valid_o,
  output logic [7:0]  char_code_o,
  output logic        has_char_o,
  output logic        last_o,
  output logic [6:0]  total_count_o
);

  import sdf_fmt_pkg::*;

  // sequencer
  state_e state_q, state_d;

  // serial conversion datapath
  logic [63:0]      mag_q, mag_d;     // magnitude, msb aligned, shifted out one bit a cycle
  logic [BCD_W-1:0] bcd_q, bcd_d;     // decimal accumulator, later the digit shift line
  logic [BCD_W-1:0] bcd_fix;          // accumulator after the add-three step
  logic [6:0]       bit_cnt_q, bit_cnt_d;
  logic [4:0]       ndig_q, ndig_d;

  // decoded request
  logic       left_q, left_d;
  logic       zpad_q, zpad_d;         // zero padding actually in effect
  logic       has_sign_q, has_sign_d;
  logic [7:0] sign_q, sign_d;
  logic [5:0] min_dig_q, min_dig_d;
  logic [5:0] width_q, width_d;

  // emission counters
  logic [6:0] lcnt_q, lcnt_d;         // leading spaces
  logic [6:0] zcnt_q, zcnt_d;         // zero padding plus precision zeros
  logic [6:0] rcnt_q, rcnt_d;         // trailing spaces
  logic [6:0] rem_q, rem_d;           // characters still to go
  logic [6:0] total_q, total_d;

  // output word
  logic       wv_d;
  logic [7:0] ch_d;
  logic       hc_d, last_d;
  logic [6:0] cnt_d;

  // accept-side decode
  logic        accept;
  logic [63:0] sx;
  logic [6:0]  nbits;
  logic        neg;
  logic [63:0] mag;
  logic [63:0] mag_al;
  logic        prec_expl, prec_pos, prec_given;

  // sizing
  logic [6:0] ndig7, md7, nzero, body, w7, pad;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  assign bcd_fix = bcd_adj(bcd_q);

  // truncate to the selected size and sign extend
  always_comb begin
    unique case (size_mode_i)
      SZ_LONG, SZ_LLONG: begin
        sx    = arg_bits_i;
        nbits = 7'd64;
      end
      SZ_SHORT: begin
        sx    = {{48{arg_bits_i[15]}}, arg_bits_i[15:0]};
        nbits = 7'd16;
      end
      SZ_CHAR: begin
        sx    = {{56{arg_bits_i[7]}}, arg_bits_i[7:0]};
        nbits = 7'd8;
      end
      default: begin
        sx    = {{32{arg_bits_i[31]}}, arg_bits_i[31:0]};
        nbits = 7'd32;
      end
    endcase
    neg = sx[63];
    mag = neg ? (~sx + 64'd1) : sx;
    // left align so the conversion always takes bits from bit 63
    unique case (size_mode_i)
      SZ_LONG, SZ_LLONG: mag_al = mag;
      SZ_SHORT:          mag_al = {mag[15:0], 48'd0};
      SZ_CHAR:           mag_al = {mag[7:0], 56'd0};
      default:           mag_al = {mag[31:0], 32'd0};
    endcase
  end

  // precision decode: explicit zero, positive, or absent
  assign prec_expl  = (precision_i == PREC_EXPL_ZERO);
  assign prec_pos   = !precision_i[6] && (precision_i != 7'd0);
  assign prec_given = prec_expl || prec_pos;

  // field sizing from digit count, precision and width
  always_comb begin
    ndig7 = {2'd0, ndig_q};
    md7   = {1'b0, min_dig_q};
    w7    = {1'b0, width_q};
    nzero = (md7 > ndig7) ? (md7 - ndig7) : 7'd0;
    body  = {6'd0, has_sign_q} + nzero + ndig7;
    pad   = (w7 > body) ? (w7 - body) : 7'd0;
  end

  always_comb begin
    state_d    = state_q;
    mag_d      = mag_q;
    bcd_d      = bcd_q;
    bit_cnt_d  = bit_cnt_q;
    ndig_d     = ndig_q;
    left_d     = left_q;
    zpad_d     = zpad_q;
    has_sign_d = has_sign_q;
    sign_d     = sign_q;
    min_dig_d  = min_dig_q;
    width_d    = width_q;
    lcnt_d     = lcnt_q;
    zcnt_d     = zcnt_q;
    rcnt_d     = rcnt_q;
    rem_d      = rem_q;
    total_d    = total_q;
    wv_d       = 1'b0;
    ch_d       = 8'd0;
    hc_d       = 1'b0;
    last_d     = 1'b0;
    cnt_d      = 7'd0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mag_d      = mag_al;
          bcd_d      = '0;
          bit_cnt_d  = nbits;
          left_d     = flag_set_i[FL_LEFT];
          zpad_d     = flag_set_i[FL_ZERO] && !flag_set_i[FL_LEFT] && !prec_given;
          has_sign_d = neg || flag_set_i[FL_PLUS] || flag_set_i[FL_SPACE];
          priority if (neg) begin
            sign_d = CH_MINUS;
          end else if (flag_set_i[FL_PLUS]) begin
            sign_d = CH_PLUS;
          end else begin
            sign_d = CH_SPACE;
          end
          priority if (prec_expl) begin
            min_dig_d = 6'd0;
          end else if (prec_pos) begin
            min_dig_d = (precision_i > 7'(FIELD_LIMIT)) ? 6'(FIELD_LIMIT) : precision_i[5:0];
          end else begin
            min_dig_d = 6'd1;
          end
          width_d = ({1'b0, field_width_i} > 7'(FIELD_LIMIT)) ? 6'(FIELD_LIMIT)
                                                                : field_width_i;
          state_d = ST_CONV;
        end
      end

      // one magnitude bit per cycle into the bcd accumulator
      ST_CONV: begin
        bcd_d     = {bcd_fix[BCD_W-2:0], mag_q[63]};
        mag_d     = {mag_q[62:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 7'd1;
        if (bit_cnt_q == 7'd1) begin
          ndig_d  = 5'(NUM_BCD);
          state_d = ST_NORM;
        end
      end

      // strip leading zero digits, one per cycle
      ST_NORM: begin
        if ((ndig_q != 5'd0) && (bcd_q[BCD_W-1 -: 4] == 4'd0)) begin
          bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
          ndig_d = ndig_q - 5'd1;
        end else begin
          state_d = ST_SIZE;
        end
      end

      ST_SIZE: begin
        lcnt_d  = (!left_q && !zpad_q) ? pad : 7'd0;
        zcnt_d  = nzero + (zpad_q ? pad : 7'd0);
        rcnt_d  = left_q ? pad : 7'd0;
        rem_d   = body + pad;
        total_d = body + pad;
        state_d = ST_EMIT;
      end

      // one character per cycle in field order
      ST_EMIT: begin
        wv_d = 1'b1;
        if (rem_q == 7'd0) begin
          // empty field marker
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          hc_d   = 1'b1;
          last_d = (rem_q == 7'd1);
          cnt_d  = (rem_q == 7'd1) ? total_q : 7'd0;
          rem_d  = rem_q - 7'd1;
          priority if (lcnt_q != 7'd0) begin
            ch_d   = CH_SPACE;
            lcnt_d = lcnt_q - 7'd1;
          end else if (has_sign_q) begin
            ch_d       = sign_q;
            has_sign_d = 1'b0;
          end else if (zcnt_q != 7'd0) begin
            ch_d   = CH_ZERO;
            zcnt_d = zcnt_q - 7'd1;
          end else if (ndig_q != 5'd0) begin
            ch_d   = CH_ZERO + {4'd0, bcd_q[BCD_W-1 -: 4]};
            bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
            ndig_d = ndig_q - 5'd1;
          end else begin
            ch_d   = CH_SPACE;
            rcnt_d = rcnt_q - 7'd1;
          end
          if (rem_q == 7'd1) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      word_valid_o  <= 1'b0;
      char_code_o   <= 8'd0;
      has_char_o    <= 1'b0;
      last_o        <= 1'b0;
      total_count_o <= 7'd0;
    end else begin
      state_q       <= state_d;
      word_valid_o  <= wv_d;
      char_code_o   <= ch_d;
      has_char_o    <= hc_d;
      last_o        <= last_d;
      total_count_o <= cnt_d;
    end
  end

  // datapath, qualified by the sequencer
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    bit_cnt_q  <= bit_cnt_d;
    ndig_q     <= ndig_d;
    left_q     <= left_d;
    zpad_q     <= zpad_d;
    has_sign_q <= has_sign_d;
    sign_q     <= sign_d;
    min_dig_q  <= min_dig_d;
    width_q    <= width_d;
    lcnt_q     <= lcnt_d;
    zcnt_q     <= zcnt_d;
    rcnt_q     <= rcnt_d;
    rem_q      <= rem_d;
    total_q    <= total_d;
  end

endmodule

/* rtl/sdf_fmt_chk.sv */
// port-level checks for the signed decimal field formatter, bound to the top level
`timescale 1ns / 1ps

module sdf_fmt_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       word_valid_o,
  input logic       has_char_o,
  input logic       last_o,
  input logic [6:0] total_count_o
);

  // count only on the closing word
  a_count_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_valid_o && !last_o) |-> (total_count_o == 7'd0))
    else $error("count on a word that is not last");

  // empty marker is a lone closing word with zero count
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_valid_o && !has_char_o) |-> (last_o && (total_count_o == 7'd0)))
    else $error("malformed empty marker");

  // closing word coincides with the block going idle, others come while busy
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_valid_o |-> (last_o == !busy_o))
    else $error("last word and busy disagree");

  // accepted request keeps the block busy and silent in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !word_valid_o))
    else $error("no busy or stray word after accept");

endmodule

bind signed_decimal_field_formatter_core sdf_fmt_chk u_sdf_fmt_chk (.*);
